@@ rtl/core/abs_pkg.sv @@
`default_nettype none

package abs_pkg;

    localparam int PAGE_OFFSET_BITS_DEF   = 12;
    localparam int BEAT_OFFSET_BITS_DEF   = 6;
    localparam int MAX_TRANSFER_BYTES_DEF = 65536;

    localparam int RESULT_LIMIT = 17;
    localparam int COUNT_W      = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic [63:0] start_address;
        logic [16:0] transfer_bytes;
    } t_req;

    typedef struct packed {
        logic [63:0] burst_address;
        logic [5:0]  burst_len_code;
        logic [63:0] first_beat_strobe;
        logic [63:0] last_beat_strobe;
        logic [12:0] burst_bytes;
        logic [15:0] buffer_offset;
        logic        final_burst;
    } t_burst;

    // count ones starting at lane shift; a count of 64 gives all ones
    function automatic logic [63:0] lane_mask(logic [6:0] count, logic [5:0] shift);
        logic [63:0] ones;
        ones = ~({64{1'b1}} << count);
        return ones << shift;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/abs_burst_unit.sv @@
`default_nettype none

module abs_burst_unit #(
    parameter int PAGE_OFFSET_BITS = abs_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int BEAT_OFFSET_BITS = abs_pkg::BEAT_OFFSET_BITS_DEF,
    parameter int REM_W            = 17
) (
    input  wire logic [63:0]      i_chunk_address,
    input  wire logic [REM_W-1:0] i_remaining,
    input  wire logic [15:0]      i_offset,
    output abs_pkg::t_burst       o_burst,
    output logic [63:0]           o_next_address,
    output logic [15:0]           o_next_offset,
    output logic [REM_W-1:0]      o_remaining_left
);
    import abs_pkg::*;

    localparam int P  = PAGE_OFFSET_BITS;
    localparam int B  = BEAT_OFFSET_BITS;
    localparam int NW = (P + 1 > REM_W) ? P + 1 : REM_W;
    localparam int LW = P - B;
    localparam logic [P:0] PAGE_BYTES = (P + 1)'(1) << P;
    localparam logic [B:0] BEAT_BYTES = (B + 1)'(1) << B;

    logic [P-1:0]  w_page_off;
    logic [P:0]    w_page_left;
    logic [NW-1:0] w_left_w;
    logic [NW-1:0] w_rem_w;
    logic [NW-1:0] w_n_w;
    logic [P:0]    w_n_bytes;
    logic [P:0]    w_last_sum;
    logic [P-1:0]  w_last_off;
    logic [LW-1:0] w_len_m1;
    logic [B-1:0]  w_first_off;
    logic [B:0]    w_first_size;
    logic [B:0]    w_last_size;
    logic [63:0]   w_first_strobe;
    logic          w_single;

    always_comb begin
        w_page_off  = i_chunk_address[P-1:0];
        w_page_left = PAGE_BYTES - {1'b0, w_page_off};
        w_left_w    = NW'(w_page_left);
        w_rem_w     = NW'(i_remaining);
        w_n_w       = (w_left_w < w_rem_w) ? w_left_w : w_rem_w;
        w_n_bytes   = (P + 1)'(w_n_w);

        w_last_sum  = {1'b0, w_page_off} + w_n_bytes - (P + 1)'(1);
        w_last_off  = w_last_sum[P-1:0];
        w_len_m1    = w_last_off[P-1:B] - w_page_off[P-1:B];
        w_single    = (w_len_m1 == '0);

        w_first_off  = w_page_off[B-1:0];
        w_first_size = w_single ? (B + 1)'(w_n_bytes) : BEAT_BYTES - {1'b0, w_first_off};
        w_last_size  = {1'b0, w_last_off[B-1:0]} + (B + 1)'(1);

        w_first_strobe = lane_mask(7'(w_first_size), 6'(w_first_off));

        o_remaining_left = i_remaining - REM_W'(w_n_w);
        o_next_address   = i_chunk_address + 64'(w_n_bytes);
        o_next_offset    = i_offset + 16'(w_n_w);

        o_burst.burst_address     = i_chunk_address;
        o_burst.burst_len_code    = 6'(w_len_m1);
        o_burst.first_beat_strobe = w_first_strobe;
        o_burst.last_beat_strobe  = w_single ? w_first_strobe
                                             : lane_mask(7'(w_last_size), 6'd0);
        o_burst.burst_bytes       = 13'(w_n_bytes);
        o_burst.buffer_offset     = i_offset;
        o_burst.final_burst       = (o_remaining_left == '0);
    end

endmodule

`default_nettype wire

@@ rtl/core/axi_burst_splitter.sv @@
`default_nettype none

// Channel   Valid          Stall           Payload
// request   i_req_valid    o_req_stall     i_req   (start address, byte count)
// burst     o_burst_valid  i_burst_stall   o_burst (one AXI4 INCR burst)
//
// A request is taken while the sequencer is idle; it then yields one burst per cycle from
// the shared burst unit, holding the input until its last burst is loaded (a zero-length
// request yields no burst and does not hold the input). Output stalls hold the sequencer.
// The burst output register frees the request side while the last burst waits.
// Synchronous active-low reset clears the sequencer and the output valid.

module axi_burst_splitter #(
    parameter int PAGE_OFFSET_BITS   = abs_pkg::PAGE_OFFSET_BITS_DEF,
    parameter int BEAT_OFFSET_BITS   = abs_pkg::BEAT_OFFSET_BITS_DEF,
    parameter int MAX_TRANSFER_BYTES = abs_pkg::MAX_TRANSFER_BYTES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_stall,
    input  wire abs_pkg::t_req   i_req,
    output logic                 o_burst_valid,
    input  wire logic            i_burst_stall,
    output abs_pkg::t_burst      o_burst
);
    import abs_pkg::*;

    localparam int REM_W = $clog2(MAX_TRANSFER_BYTES + 1);

    typedef enum logic {
        S_IDLE,
        S_SPLIT
    } t_state;

    t_state             r_state;
    logic [63:0]        r_chunk;
    logic [REM_W-1:0]   r_remaining;
    logic [15:0]        r_offset;
    logic [COUNT_W-1:0] r_count;
    logic               r_burst_valid;
    t_burst             r_burst;

    t_burst             w_step;
    logic [63:0]        n_chunk;
    logic [15:0]        n_offset;
    logic [REM_W-1:0]   n_remaining;
    logic [REM_W-1:0]   w_req_bytes;
    logic               w_req_acc;
    logic               w_load;

    abs_burst_unit #(
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
        .BEAT_OFFSET_BITS (BEAT_OFFSET_BITS),
        .REM_W            (REM_W)
    ) u_unit (
        .i_chunk_address  (r_chunk),
        .i_remaining      (r_remaining),
        .i_offset         (r_offset),
        .o_burst          (w_step),
        .o_next_address   (n_chunk),
        .o_next_offset    (n_offset),
        .o_remaining_left (n_remaining)
    );

    always_comb begin
        if ({15'd0, i_req.transfer_bytes} > 32'(MAX_TRANSFER_BYTES)) begin
            w_req_bytes = REM_W'(MAX_TRANSFER_BYTES);
        end else begin
            w_req_bytes = REM_W'(i_req.transfer_bytes);
        end
        w_req_acc = i_req_valid && (r_state == S_IDLE);
        w_load    = (r_state == S_SPLIT) && (!r_burst_valid || !i_burst_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_burst_valid <= 1'b0;
            r_count       <= '0;
            r_chunk       <= '0;
            r_remaining   <= '0;
            r_offset      <= '0;
            r_burst       <= '0;
        end else begin
            if (r_burst_valid && !i_burst_stall && !w_load) begin
                r_burst_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_req_acc) begin
                        r_chunk     <= i_req.start_address;
                        r_remaining <= w_req_bytes;
                        r_offset    <= '0;
                        r_count     <= '0;
                        if (w_req_bytes != '0) begin
                            r_state <= S_SPLIT;
                        end
                    end
                end
                S_SPLIT: begin
                    if (w_load) begin
                        r_burst       <= w_step;
                        r_burst_valid <= 1'b1;
                        r_chunk       <= n_chunk;
                        r_remaining   <= n_remaining;
                        r_offset      <= n_offset;
                        r_count       <= r_count + COUNT_W'(1);
                        if (w_step.final_burst ||
                            r_count == COUNT_W'(RESULT_LIMIT - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_stall   = (r_state != S_IDLE);
    assign o_burst_valid = r_burst_valid;
    assign o_burst       = r_burst;

    a_split_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_remaining != '0))
        else $error("splitting with no bytes left");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_count < COUNT_W'(RESULT_LIMIT)))
        else $error("burst count beyond limit");

    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_step.final_burst) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final burst");

    a_first_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst_valid |-> (o_burst.first_beat_strobe != '0))
        else $error("empty first-beat strobe");

endmodule

`default_nettype wire

@@ tb/sv/axi_burst_splitter_tb.sv @@
module axi_burst_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BITS       = abs_pkg::PAGE_OFFSET_BITS_DEF;
    localparam int BEAT_BITS       = abs_pkg::BEAT_OFFSET_BITS_DEF;
    localparam int MAX_BYTES       = abs_pkg::MAX_TRANSFER_BYTES_DEF;
    localparam int PAGE_BYTES      = 1 << PAGE_BITS;
    localparam int BEAT_BYTES      = 1 << BEAT_BITS;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_LIMIT    = 10;

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_req_valid   = 1'b0;
    abs_pkg::t_req   i_req         = '0;
    logic            i_burst_stall = 1'b0;
    logic            o_req_stall;
    logic            o_burst_valid;
    abs_pkg::t_burst o_burst;

    abs_pkg::t_burst expected_bursts[$];
    int              mismatch_count = 0;
    int              quiet_cycles   = 0;
    int              cycle_count    = 0;
    int              run_left       = 0;
    bit              pace_gaps      = 1'b1;
    bit              hold_off_req   = 1'b0;
    bit              sink_holding   = 1'b0;

    axi_burst_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_req         (i_req),
        .o_burst_valid (o_burst_valid),
        .i_burst_stall (i_burst_stall),
        .o_burst       (o_burst)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] byte_lanes(int count, int shift);
        logic [63:0] ones;
        ones = (count >= 64) ? {64{1'b1}} : (64'd1 << count) - 64'd1;
        return ones << shift;
    endfunction

    // page-bounded bursts for one request, in address order
    task automatic predict_bursts(input abs_pkg::t_req req);
        logic [63:0]     chunk;
        int              left;
        int              buf_off;
        int              page_off;
        int              span;
        int              last_off;
        int              beats;
        int              lead;
        int              produced;
        abs_pkg::t_burst b;
        chunk    = req.start_address;
        left     = int'(req.transfer_bytes);
        if (left > MAX_BYTES) begin
            left = MAX_BYTES;
        end
        buf_off  = 0;
        produced = 0;
        while (left != 0 && produced < abs_pkg::RESULT_LIMIT) begin
            page_off = int'(chunk & 64'(PAGE_BYTES - 1));
            span     = PAGE_BYTES - page_off;
            if (span > left) begin
                span = left;
            end
            last_off = page_off + span - 1;
            beats    = (last_off >> BEAT_BITS) - (page_off >> BEAT_BITS) + 1;
            lead     = page_off % BEAT_BYTES;
            b.burst_address  = chunk;
            b.burst_len_code = 6'(beats - 1);
            if (beats == 1) begin
                b.first_beat_strobe = byte_lanes(span, lead);
                b.last_beat_strobe  = b.first_beat_strobe;
            end else begin
                b.first_beat_strobe = byte_lanes(BEAT_BYTES - lead, lead);
                b.last_beat_strobe  = byte_lanes(last_off % BEAT_BYTES + 1, 0);
            end
            b.burst_bytes   = 13'(span);
            b.buffer_offset = 16'(buf_off);
            left            = left - span;
            b.final_burst   = (left == 0);
            expected_bursts.push_back(b);
            chunk    = chunk + 64'(span);
            buf_off  = buf_off + span;
            produced = produced + 1;
        end
    endtask

    task automatic compare_burst(input abs_pkg::t_burst due, input abs_pkg::t_burst got);
        if (got.burst_address !== due.burst_address ||
            got.burst_len_code !== due.burst_len_code ||
            got.first_beat_strobe !== due.first_beat_strobe ||
            got.last_beat_strobe !== due.last_beat_strobe ||
            got.burst_bytes !== due.burst_bytes ||
            got.buffer_offset !== due.buffer_offset ||
            got.final_burst !== due.final_burst) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("burst mismatch at %0t", $realtime);
                $display("  exp addr=%h len=%0d bytes=%0d off=%0d fin=%b",
                         due.burst_address, due.burst_len_code, due.burst_bytes,
                         due.buffer_offset, due.final_burst);
                $display("      first=%h last=%h", due.first_beat_strobe,
                         due.last_beat_strobe);
                $display("  got addr=%h len=%0d bytes=%0d off=%0d fin=%b",
                         got.burst_address, got.burst_len_code, got.burst_bytes,
                         got.buffer_offset, got.final_burst);
                $display("      first=%h last=%h", got.first_beat_strobe,
                         got.last_beat_strobe);
            end
        end
    endtask

    // predict on request handshake first, so same-edge bursts find their expectation
    always @(posedge i_clk) begin : burst_monitor
        abs_pkg::t_burst due;
        if (i_rst_n) begin
            if (i_req_valid && !o_req_stall) begin
                predict_bursts(i_req);
            end
            if (o_burst_valid && !i_burst_stall) begin
                if (expected_bursts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("unexpected burst addr=%h bytes=%0d at %0t",
                                 o_burst.burst_address, o_burst.burst_bytes, $realtime);
                    end
                end else begin
                    due = expected_bursts.pop_front();
                    compare_burst(due, o_burst);
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
            if ((i_req_valid && !o_req_stall) || (o_burst_valid && !i_burst_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : burst_sink
        int mode;
        int span;
        int k;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                sink_holding = 1'b1;
                i_burst_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                sink_holding = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
                for (k = 0; k < span && !hold_off_req; k++) begin
                    case (mode)
                        0: begin
                            i_burst_stall <= 1'b0;
                        end
                        1: begin
                            i_burst_stall <= ($urandom_range(0, 3) == 0);
                        end
                        2: begin
                            i_burst_stall <= ($urandom_range(0, 3) != 0);
                        end
                        default: begin
                            i_burst_stall <= ((cycle_count % 7) < 3);
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // called at a rising edge; returns at the edge that took the request
    task automatic send_request(input abs_pkg::t_req req);
        int gap;
        if (run_left == 0) begin
            run_left = $urandom_range(1, 12);
            gap      = 0;
            if (pace_gaps && $urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 9);
            end
            if (gap != 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        @(posedge i_clk);
        while (o_req_stall) begin
            @(posedge i_clk);
        end
        run_left--;
    endtask

    task automatic request_span(input logic [63:0] addr, input logic [16:0] bytes);
        abs_pkg::t_req req;
        req.start_address  = addr;
        req.transfer_bytes = bytes;
        send_request(req);
    endtask

    function automatic abs_pkg::t_req random_request();
        abs_pkg::t_req req;
        int            pick;
        req.start_address = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: begin
                req.start_address[PAGE_BITS-1:0] =
                    PAGE_BITS'(PAGE_BYTES - $urandom_range(1, 130));
            end
            1: begin
                req.start_address[BEAT_BITS-1:0] = '0;
            end
            2: begin
                req.start_address = {64{1'b1}} - 64'($urandom_range(0, 70000));
            end
            default: begin
            end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            req.transfer_bytes = '0;
        end else if (pick < 60) begin
            req.transfer_bytes = 17'($urandom_range(1, 256));
        end else if (pick < 85) begin
            req.transfer_bytes = 17'($urandom_range(257, 8192));
        end else if (pick < 95) begin
            req.transfer_bytes = 17'($urandom_range(8193, MAX_BYTES));
        end else begin
            req.transfer_bytes = 17'($urandom_range(MAX_BYTES + 1, 131071));
        end
        return req;
    endfunction

    task automatic test_directed_spans();
        request_span(64'h0, 17'd0);
        request_span(64'h0, 17'd1);
        request_span(64'h40, 17'd64);
        request_span(64'h3F, 17'd1);
        request_span(64'h3F, 17'd2);
        request_span(64'h1000, 17'd4096);
        request_span(64'h1001, 17'd4096);
        request_span(64'h1, 17'd4095);
        request_span(64'h2000, 17'd65536);
        request_span(64'h0FFF, 17'd65536);
        request_span(64'h1234_5678_9ABC_DEF0, 17'h1FFFF);
        request_span(64'h0000_0000_0000_8020, 17'd65537);
        request_span(64'hFFFF_FFFF_FFFF_FF80, 17'h2000);
        request_span(64'hFFFF_FFFF_FFFF_FFFF, 17'd2);
        request_span(64'hFFFF_FFFF_FFFF_FFC0, 17'd64);
        request_span(64'hFFFF_FFFF_FFFF_FFFF, 17'd0);
        request_span(64'h5555_5555_5555_5555, 17'h0FFFF);
        request_span(64'hAAAA_AAAA_AAAA_AAAA, 17'h15555);
        request_span(64'h0000_0000_0000_0FC1, 17'd200);
    endtask

    task automatic test_random_spans(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_request(random_request());
        end
    endtask

    // sink holds off while requests keep coming, so the splitter backs up
    task automatic test_stalled_sink();
        int k;
        pace_gaps = 1'b0;
        i_req_valid <= 1'b0;
        hold_off_req = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!sink_holding);
        for (k = 0; k < 24; k++) begin
            send_request(random_request());
        end
        pace_gaps = 1'b1;
    endtask

    initial begin : main_sequence
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_spans();
        test_random_spans(110);
        test_stalled_sink();
        test_random_spans(120);
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bursts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_bursts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/abs_pkg.sv
rtl/core/abs_burst_unit.sv
rtl/core/axi_burst_splitter.sv
tb/sv/axi_burst_splitter_tb.sv
